// ----- sv/incremental_pid_antiwindup_unit_assert.svh -----
// Assertion macros for the incremental PID unit checker.
// Each macro expects clk_i and rst_ni in scope where it is used.
`ifndef INCREMENTAL_PID_ANTIWINDUP_UNIT_ASSERT_SVH
`define INCREMENTAL_PID_ANTIWINDUP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IPID_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPID_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ipid_pkg.sv -----
// Shared widths, register indexes and limit codes of the incremental PID unit.
// No dependencies; used by the top level and its checker.
package ipid_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned DRIVE_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned SUM_W     = 46;

  localparam logic signed [POS_W-1:0] OUT_MAX_RST = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] OUT_MIN_RST = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP           = 3'd0,
    REG_KI_HALF_T    = 3'd1,
    REG_KD_OVER_T    = 3'd2,
    REG_CLAMP_ENABLE = 3'd3,
    REG_OUT_MAX      = 3'd4,
    REG_OUT_MIN      = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EXC_NONE  = 2'd0,
    EXC_ABOVE = 2'd1,
    EXC_BELOW = 2'd2
  } excess_e;

endpackage

// ----- sv/incremental_pid_antiwindup_unit.sv -----
// Incremental PID unit with input, product and output stage registers. Unless the
// output stalls, throughput one word per cycle; the output stage closes the loop on the
// previous drive and limit state with a three-input add, a limit compare, a clamp and a
// saturate. Reset clears gains, error history, previous drive and all valid flags; the
// limits reset to the full integer range.
// Depends on ipid_pkg.
module incremental_pid_antiwindup_unit #(
  parameter int unsigned FRAC_BITS = ipid_pkg::FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [ipid_pkg::CFG_DAT_W-1:0]          cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [ipid_pkg::POS_W-1:0]       setpoint_i,
  input  logic signed [ipid_pkg::POS_W-1:0]       measured_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [ipid_pkg::DRIVE_W-1:0]     drive_o,
  output logic signed [ipid_pkg::POS_W-1:0]       error_now_o,
  output logic                                    limited_o
);

  localparam int unsigned GW = ipid_pkg::GAIN_W;
  localparam int unsigned PW = ipid_pkg::POS_W;
  localparam int unsigned DW = ipid_pkg::DRIVE_W;
  localparam int unsigned SW = ipid_pkg::SUM_W;

  localparam logic signed [SW-1:0] DRV_MAX =
    $signed({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [SW-1:0] DRV_MIN =
    $signed({{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}});

  logic signed [GW-1:0] kp_q, ki_q, kd_q;
  logic                 clamp_en_q;
  logic signed [PW-1:0] out_max_q, out_min_q;

  logic signed [PW-1:0] err_prev1_q, err_prev2_q;
  logic signed [DW-1:0] drive_prev_q;
  ipid_pkg::excess_e    exc_q, exc_d;

  logic                 s1_vld_q, s2_vld_q, out_vld_q;
  logic signed [PW-1:0] s1_e_q, s1_e1_q, s1_e2_q;
  logic signed [PW-1:0] s2_e_q;
  logic signed [SW-1:0] s2_pd_q, s2_pi_q, s2_pd_d, s2_pi_d;

  logic signed [DW-1:0] drive_q, drive_d;
  logic signed [PW-1:0] err_out_q;
  logic                 lim_q, lim_d;

  logic                 in_acc, adv2, take_o;
  logic signed [PW-1:0] e_d;

  logic signed [PW:0]   sum_e, diff_e;
  logic signed [PW+1:0] dd_e;
  logic signed [GW+PW:0]   prod_p, prod_i;
  logic signed [GW+PW+1:0] prod_d;

  // handshake
  assign take_o      = s2_vld_q && (!out_vld_q || out_ready_i);
  assign adv2        = s1_vld_q && (!s2_vld_q || take_o);
  assign in_ready_o  = !s1_vld_q || !s2_vld_q || take_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;
  assign error_now_o = err_out_q;
  assign limited_o   = lim_q;

  assign e_d = setpoint_i - measured_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      clamp_en_q <= 1'b0;
      out_max_q  <= ipid_pkg::OUT_MAX_RST;
      out_min_q  <= ipid_pkg::OUT_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ipid_pkg::cfg_reg_e'(cfg_index_i))
        ipid_pkg::REG_KP:           kp_q       <= cfg_data_i[GW-1:0];
        ipid_pkg::REG_KI_HALF_T:    ki_q       <= cfg_data_i[GW-1:0];
        ipid_pkg::REG_KD_OVER_T:    kd_q       <= cfg_data_i[GW-1:0];
        ipid_pkg::REG_CLAMP_ENABLE: clamp_en_q <= cfg_data_i[0];
        ipid_pkg::REG_OUT_MAX:      out_max_q  <= cfg_data_i[PW-1:0];
        ipid_pkg::REG_OUT_MIN:      out_min_q  <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // input stage: error and its history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_prev1_q <= '0;
      err_prev2_q <= '0;
    end else if (in_acc) begin
      err_prev1_q <= e_d;
      err_prev2_q <= err_prev1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_e_q  <= e_d;
      s1_e1_q <= err_prev1_q;
      s1_e2_q <= err_prev2_q;
    end
  end

  // product stage
  assign sum_e  = (PW+1)'(s1_e_q) + (PW+1)'(s1_e1_q);
  assign diff_e = (PW+1)'(s1_e_q) - (PW+1)'(s1_e1_q);
  assign dd_e   = (PW+2)'(s1_e_q) - ((PW+2)'(s1_e1_q) <<< 1) + (PW+2)'(s1_e2_q);

  assign prod_p = kp_q * diff_e;
  assign prod_i = ki_q * sum_e;
  assign prod_d = kd_q * dd_e;

  assign s2_pd_d = SW'(prod_p) + SW'(prod_d);
  assign s2_pi_d = SW'(prod_i);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_pd_q <= s2_pd_d;
      s2_pi_q <= s2_pi_d;
      s2_e_q  <= s1_e_q;
    end
  end

  // output stage: accumulate, anti-windup, clamp, saturate
  always_comb begin
    logic                 e_pos, e_neg, ki_pos, ki_neg, drop;
    logic signed [SW-1:0] hi, lo, sum, u;
    e_pos  = !s2_e_q[PW-1] && (s2_e_q != '0);
    e_neg  = s2_e_q[PW-1];
    ki_pos = !ki_q[GW-1] && (ki_q != '0);
    ki_neg = ki_q[GW-1];
    drop   = clamp_en_q &&
             ((exc_q == ipid_pkg::EXC_ABOVE && ((e_pos && ki_pos) || (e_neg && ki_neg))) ||
              (exc_q == ipid_pkg::EXC_BELOW && ((e_pos && ki_neg) || (e_neg && ki_pos))));
    hi  = SW'(out_max_q) <<< FRAC_BITS;
    lo  = SW'(out_min_q) <<< FRAC_BITS;
    sum = SW'(drive_prev_q) + s2_pd_q + (drop ? SW'(0) : s2_pi_q);

    if (sum > hi) begin
      exc_d = ipid_pkg::EXC_ABOVE;
    end else if (sum < lo) begin
      exc_d = ipid_pkg::EXC_BELOW;
    end else begin
      exc_d = ipid_pkg::EXC_NONE;
    end

    u     = sum;
    lim_d = 1'b0;
    if (clamp_en_q) begin
      if (sum > hi) begin
        u     = hi;
        lim_d = 1'b1;
      end else if (sum < lo) begin
        u     = lo;
        lim_d = 1'b1;
      end
    end
    if (u > DRV_MAX) begin
      u     = DRV_MAX;
      lim_d = 1'b1;
    end else if (u < DRV_MIN) begin
      u     = DRV_MIN;
      lim_d = 1'b1;
    end
    drive_d = u[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_prev_q <= '0;
      exc_q        <= ipid_pkg::EXC_NONE;
    end else if (take_o) begin
      drive_prev_q <= drive_d;
      exc_q        <= exc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      drive_q   <= drive_d;
      err_out_q <= s2_e_q;
      lim_q     <= lim_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (adv2) begin
        s1_vld_q <= 1'b0;
      end
      if (adv2) begin
        s2_vld_q <= 1'b1;
      end else if (take_o) begin
        s2_vld_q <= 1'b0;
      end
      if (take_o) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/ipid_checker.sv -----
// Port-level checker for the incremental PID unit, bound to the top level.
// Depends on ipid_pkg and incremental_pid_antiwindup_unit_assert.svh.
`include "incremental_pid_antiwindup_unit_assert.svh"

module ipid_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [ipid_pkg::DRIVE_W-1:0] drive_o,
  input logic signed [ipid_pkg::POS_W-1:0]   error_now_o,
  input logic                                limited_o
);

  `IPID_ASSERT_IMPL(a_empty_out_takes_in, !out_valid_o, in_ready_o, "input stalled with empty output")
  `IPID_ASSERT_IMPL(a_word_from_input, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 3), "output word without input three cycles back")
  `IPID_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_o) && $stable(error_now_o) && $stable(limited_o), "stalled output word changed")

endmodule

bind incremental_pid_antiwindup_unit ipid_checker u_ipid_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for incremental_pid_antiwindup_unit: directed and random PID samples,
// checked word by word against a cycle-free predictor of the control law.
// Depends on ipid_pkg and the unit RTL.
module tb;

  localparam int unsigned FRAC      = ipid_pkg::FRAC_BITS;
  localparam int          PIPE_LAT  = 3;
  localparam longint      DRIVE_MAX = (longint'(1) <<< 31) - 1;
  localparam longint      DRIVE_MIN = -(longint'(1) <<< 31);

  typedef struct {
    logic signed [ipid_pkg::DRIVE_W-1:0] drive;
    logic signed [ipid_pkg::POS_W-1:0]   error_now;
    logic                                limited;
  } pid_word_t;

  logic                                    clk_i;
  logic                                    rst_ni      = 1'b0;
  logic                                    cfg_valid_i = 1'b0;
  logic                                    cfg_ready_o;
  logic [ipid_pkg::CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [ipid_pkg::CFG_DAT_W-1:0]          cfg_data_i  = '0;
  logic                                    in_valid_i  = 1'b0;
  logic                                    in_ready_o;
  logic signed [ipid_pkg::POS_W-1:0]       setpoint_i  = '0;
  logic signed [ipid_pkg::POS_W-1:0]       measured_i  = '0;
  logic                                    out_valid_o;
  logic                                    out_ready_i = 1'b1;
  logic signed [ipid_pkg::DRIVE_W-1:0]     drive_o;
  logic signed [ipid_pkg::POS_W-1:0]       error_now_o;
  logic                                    limited_o;

  // predictor copy of registers and loop state
  logic signed [ipid_pkg::GAIN_W-1:0]  gain_kp     = '0;
  logic signed [ipid_pkg::GAIN_W-1:0]  gain_ki     = '0;
  logic signed [ipid_pkg::GAIN_W-1:0]  gain_kd     = '0;
  logic                                clamp_on    = 1'b0;
  logic signed [ipid_pkg::POS_W-1:0]   lim_hi      = ipid_pkg::OUT_MAX_RST;
  logic signed [ipid_pkg::POS_W-1:0]   lim_lo      = ipid_pkg::OUT_MIN_RST;
  logic signed [ipid_pkg::POS_W-1:0]   err_d1      = '0;
  logic signed [ipid_pkg::POS_W-1:0]   err_d2      = '0;
  logic signed [ipid_pkg::DRIVE_W-1:0] drive_last  = '0;
  ipid_pkg::excess_e                   excess_last = ipid_pkg::EXC_NONE;

  pid_word_t pid_words_due[$];
  pid_word_t want;
  int        mismatches         = 0;
  int        sender_idle_pct    = 0;
  int        receiver_stall_pct = 0;

  incremental_pid_antiwindup_unit #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .error_now_o (error_now_o),
    .limited_o   (limited_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic pid_word_t pid_step(logic signed [ipid_pkg::POS_W-1:0] sp,
                                         logic signed [ipid_pkg::POS_W-1:0] ms);
    logic signed [ipid_pkg::POS_W-1:0] err;
    longint e, e1, e2, p, ki, kd, one, hi, lo, sum, u;
    pid_word_t w;
    err = sp - ms;
    e   = err;
    e1  = err_d1;
    e2  = err_d2;
    p   = gain_kp;
    ki  = gain_ki;
    kd  = gain_kd;
    one = longint'(1) <<< FRAC;
    hi  = longint'(lim_hi) * one;
    lo  = longint'(lim_lo) * one;
    if (clamp_on) begin
      if ((excess_last == ipid_pkg::EXC_ABOVE && e * ki > 0) ||
          (excess_last == ipid_pkg::EXC_BELOW && e * ki < 0)) ki = 0;
    end
    sum = (p + ki + kd) * e + (-p + ki - 2 * kd) * e1 + kd * e2 + longint'(drive_last);
    if (sum > hi) excess_last = ipid_pkg::EXC_ABOVE;
    else if (sum < lo) excess_last = ipid_pkg::EXC_BELOW;
    else excess_last = ipid_pkg::EXC_NONE;
    u = sum;
    w.limited = 1'b0;
    if (clamp_on) begin
      if (u > hi) begin
        u = hi;
        w.limited = 1'b1;
      end else if (u < lo) begin
        u = lo;
        w.limited = 1'b1;
      end
    end
    if (u > DRIVE_MAX) begin
      u = DRIVE_MAX;
      w.limited = 1'b1;
    end else if (u < DRIVE_MIN) begin
      u = DRIVE_MIN;
      w.limited = 1'b1;
    end
    err_d2      = err_d1;
    err_d1      = err;
    drive_last  = u[ipid_pkg::DRIVE_W-1:0];
    w.drive     = drive_last;
    w.error_now = err;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (mismatches < 100) $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pid_words_due.size() == 0) begin
        report_mismatch("output word with none pending", drive_o, 0);
      end else begin
        want = pid_words_due.pop_front();
        if (drive_o !== want.drive) report_mismatch("drive", drive_o, want.drive);
        if (error_now_o !== want.error_now)
          report_mismatch("error_now", error_now_o, want.error_now);
        if (limited_o !== want.limited) report_mismatch("limited", limited_o, want.limited);
      end
    end
  end

  task automatic send_sample(input logic signed [ipid_pkg::POS_W-1:0] sp,
                             input logic signed [ipid_pkg::POS_W-1:0] ms);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measured_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    pid_words_due.push_back(pid_step(sp, ms));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pid_words_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(input ipid_pkg::cfg_reg_e r,
                           input logic [ipid_pkg::CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (r)
      ipid_pkg::REG_KP:           gain_kp  = d;
      ipid_pkg::REG_KI_HALF_T:    gain_ki  = d;
      ipid_pkg::REG_KD_OVER_T:    gain_kd  = d;
      ipid_pkg::REG_CLAMP_ENABLE: clamp_on = d[0];
      ipid_pkg::REG_OUT_MAX:      lim_hi   = d[ipid_pkg::POS_W-1:0];
      ipid_pkg::REG_OUT_MIN:      lim_lo   = d[ipid_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [ipid_pkg::GAIN_W-1:0] kp,
                           input logic [ipid_pkg::GAIN_W-1:0] ki,
                           input logic [ipid_pkg::GAIN_W-1:0] kd, input logic clamp,
                           input logic [ipid_pkg::POS_W-1:0] hi,
                           input logic [ipid_pkg::POS_W-1:0] lo);
    wait_idle();
    write_reg(ipid_pkg::REG_KP, kp);
    write_reg(ipid_pkg::REG_KI_HALF_T, ki);
    write_reg(ipid_pkg::REG_KD_OVER_T, kd);
    write_reg(ipid_pkg::REG_CLAMP_ENABLE, {{(ipid_pkg::CFG_DAT_W-1){1'b0}}, clamp});
    write_reg(ipid_pkg::REG_OUT_MAX,
              {{(ipid_pkg::CFG_DAT_W-ipid_pkg::POS_W){hi[ipid_pkg::POS_W-1]}}, hi});
    write_reg(ipid_pkg::REG_OUT_MIN,
              {{(ipid_pkg::CFG_DAT_W-ipid_pkg::POS_W){lo[ipid_pkg::POS_W-1]}}, lo});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ipid_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1, 2, 3: return ipid_pkg::GAIN_W'($urandom_range(2048)) - ipid_pkg::GAIN_W'(1024);
      4, 5:    return ipid_pkg::GAIN_W'($urandom_range(262144)) - ipid_pkg::GAIN_W'(131072);
      6:       return ipid_pkg::GAIN_W'($urandom);
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  task automatic random_config();
    logic signed [ipid_pkg::POS_W-1:0] a, b, hi, lo;
    a = ipid_pkg::POS_W'($urandom);
    b = ipid_pkg::POS_W'($urandom);
    case ($urandom_range(3))
      0: begin
        hi = ipid_pkg::OUT_MAX_RST;
        lo = ipid_pkg::OUT_MIN_RST;
      end
      1: begin
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
      end
      2: begin
        hi = (a > b) ? b : a;
        lo = (a > b) ? a : b;
      end
      default: begin
        hi = ipid_pkg::POS_W'($urandom_range(200));
        lo = ipid_pkg::POS_W'(0 - $urandom_range(200));
      end
    endcase
    configure(pick_gain(), pick_gain(), pick_gain(), $urandom_range(2) != 0, hi, lo);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sd100, 16'sd40);
    send_sample(-16'sd5, 16'sd7);
    send_sample(16'sd0, 16'sd0);
  endtask

  task automatic test_input_extremes();
    configure(24'h010000, 24'h008000, 24'h004000, 1'b0,
              ipid_pkg::OUT_MAX_RST, ipid_pkg::OUT_MIN_RST);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000);
  endtask

  task automatic test_saturation();
    configure(24'h7FFFFF, 24'h000000, 24'h800000, 1'b0,
              ipid_pkg::OUT_MAX_RST, ipid_pkg::OUT_MIN_RST);
    send_sample(16'sh7FFF, 16'sh0000);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
  endtask

  task automatic test_antiwindup();
    configure(24'h000000, 24'h010000, 24'h000000, 1'b1, 16'sd10, -16'sd10);
    send_sample(16'sd8, 16'sd0);
    send_sample(16'sd8, 16'sd0);
    send_sample(16'sd8, 16'sd0);
    send_sample(-16'sd8, 16'sd0);
    configure(24'h000000, 24'hFF0000, 24'h000000, 1'b1, 16'sd10, -16'sd10);
    send_sample(16'sd8, 16'sd0);
    send_sample(16'sd8, 16'sd0);
    send_sample(16'sd8, 16'sd0);
    send_sample(-16'sd8, 16'sd0);
  endtask

  task automatic test_crossed_limits();
    configure(24'h010000, 24'h000000, 24'h000000, 1'b1, -16'sd5, 16'sd5);
    send_sample(16'sd3, 16'sd0);
    send_sample(-16'sd20, 16'sd0);
    send_sample(16'sd40, 16'sd0);
    send_sample(16'sd0, 16'sd0);
  endtask

  task automatic test_random(input int send_pct, input int stall_pct, input int n_items,
                             input bit drain_midway);
    logic signed [ipid_pkg::POS_W-1:0] sp, ms;
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
    for (int s = 0; s < 3; s++) begin
      random_config();
      for (int i = 0; i < n_items / 3; i++) begin
        sp = ipid_pkg::POS_W'($urandom);
        case ($urandom_range(4))
          0, 1: ms = ipid_pkg::POS_W'($urandom);
          2, 3: ms = sp + ipid_pkg::POS_W'($urandom_range(64)) - ipid_pkg::POS_W'(32);
          default: begin
            sp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            ms = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          end
        endcase
        send_sample(sp, ms);
        if (drain_midway && s == 1 && i == n_items / 6) wait_idle();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    test_reset_defaults();
    test_input_extremes();
    test_saturation();
    test_antiwindup();
    test_crossed_limits();
    test_random(0, 0, 486, 1'b0);
    test_random(85, 0, 486, 1'b1);
    test_random(0, 85, 486, 1'b0);
    test_random(27, 27, 486, 1'b0);
    in_valid_i <= 1'b0;
    while (pid_words_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- incremental_pid_antiwindup_unit.f -----
+incdir+sv
sv/ipid_pkg.sv
sv/incremental_pid_antiwindup_unit.sv
sv/ipid_checker.sv
test/tb.sv
